// ===== rtl/core/pffl_pkg.sv =====
// ----------------------------------------------------------------------------
// pffl_pkg: shared types and constants for the page frame replacer
// Defaults for the parameters, channel widths, sequencer states, datapath
// operation codes and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package pffl_pkg;

  localparam int PROCESSES_DEF = 4;
  localparam int PAGE_BITS_DEF = 12;
  localparam int FRAMES_DEF    = 16;

  localparam int PID_FIELD_W   = 2;
  localparam int PAGE_FIELD_W  = 12;
  localparam int FRAME_FIELD_W = 4;
  localparam int COUNT_W       = 32;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 88;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWN,
    ST_CHK,
    ST_MV1,
    ST_MV2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_OWNRD,
    OP_CHECK,
    OP_MOVE1,
    OP_MOVE2,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic pid_ok;     // incoming process number is in range
    logic need_move;  // the checked access must relink or evict
    logic more_move;  // the frame is not yet at the newest end
    logic out_free;   // the result register can take a new item
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/pffl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pffl_ctrl: access sequencer
// Steps each accepted access through table read, owner check, relink and
// result hand-off, one datapath operation per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module pffl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pffl_pkg::status_t st,
  output pffl_pkg::cmd_t    cmd
);

  pffl_pkg::state_t state_r;
  pffl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pffl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pffl_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      pffl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = pffl_pkg::OP_ACCEPT;
          // Out-of-range processes are dropped without a result.
          if (st.pid_ok) state_nxt = pffl_pkg::ST_OWN;
        end
      end
      pffl_pkg::ST_OWN: begin
        cmd.op    = pffl_pkg::OP_OWNRD;
        state_nxt = pffl_pkg::ST_CHK;
      end
      pffl_pkg::ST_CHK: begin
        cmd.op    = pffl_pkg::OP_CHECK;
        state_nxt = st.need_move ? pffl_pkg::ST_MV1 : pffl_pkg::ST_DONE;
      end
      pffl_pkg::ST_MV1: begin
        cmd.op    = pffl_pkg::OP_MOVE1;
        state_nxt = st.more_move ? pffl_pkg::ST_MV2 : pffl_pkg::ST_DONE;
      end
      pffl_pkg::ST_MV2: begin
        cmd.op    = pffl_pkg::OP_MOVE2;
        state_nxt = pffl_pkg::ST_DONE;
      end
      pffl_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.op    = pffl_pkg::OP_FINISH;
          state_nxt = pffl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pffl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pffl_dp.sv =====
// ----------------------------------------------------------------------------
// pffl_dp: page table, frame owners, recency list and counters
// Holds the memories and registers of the replacer and carries out the
// operation that the sequencer selects in each cycle.
// ----------------------------------------------------------------------------
module pffl_dp #(
  parameter int PROCESSES        = pffl_pkg::PROCESSES_DEF,
  parameter int PAGE_NUMBER_BITS = pffl_pkg::PAGE_BITS_DEF,
  parameter int FRAMES           = pffl_pkg::FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pffl_pkg::cmd_t                      cmd,
  output pffl_pkg::status_t                   st,
  input  logic [pffl_pkg::PID_FIELD_W-1:0]    in_pid,
  input  logic [pffl_pkg::PAGE_FIELD_W-1:0]   in_page,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pffl_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int PID_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int FB    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int UB    = $clog2(FRAMES + 1);
  localparam int OWN_W = PID_W + PAGE_NUMBER_BITS;
  localparam int DEPTH = PROCESSES << PAGE_NUMBER_BITS;
  localparam int CW    = pffl_pkg::COUNT_W;

  // Memories. A page counts as resident only when its table entry names a
  // frame in use whose owner is that very page, so the table needs no
  // valid bits and no clearing after reset. The table still starts from a
  // known content so that a never-used entry yields a defined frame number.
  logic [FB-1:0]    pt_mem  [DEPTH] = '{default: '0};
  logic [OWN_W-1:0] own_mem [FRAMES];
  logic [FB-1:0]    nxt_mem [FRAMES];
  logic [FB-1:0]    prv_mem [FRAMES];

  logic [FB-1:0]    pt_rd_r;
  logic [OWN_W-1:0] own_rd_r;
  logic [FB-1:0]    nxt_rd_r;
  logic [FB-1:0]    prv_rd_r;

  logic [PID_W-1:0]            pid_r;
  logic [PAGE_NUMBER_BITS-1:0] page_r;
  logic [FB-1:0]               f_r;
  logic                        hit_r;
  logic                        ev_r;
  logic [PID_W-1:0]            vproc_r;
  logic [PAGE_NUMBER_BITS-1:0] vpage_r;
  logic [FB-1:0]               oldest_r;
  logic [FB-1:0]               newest_r;
  logic [UB-1:0]               used_r;
  logic                        policy_r;
  logic [CW-1:0]               hit_cnt_r   [PROCESSES];
  logic [CW-1:0]               fault_cnt_r [PROCESSES];
  logic                        out_vld_r;
  logic [pffl_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [31:0]                 pid_ext;
  logic [31:0]                 page_ext;
  logic [31:0]                 used_ext;
  logic [PID_W-1:0]            pid_in;
  logic [PAGE_NUMBER_BITS-1:0] page_in;
  logic [FB-1:0]               f_free;
  logic                        hit_c;
  logic                        full_c;

  logic             pt_we;
  logic [FB-1:0]    pt_wd;
  logic             own_we;
  logic [FB-1:0]    own_wa;
  logic             own_re;
  logic [FB-1:0]    own_ra;
  logic             nxt_we;
  logic [FB-1:0]    nxt_wa;
  logic [FB-1:0]    nxt_wd;
  logic             prv_we;
  logic [FB-1:0]    prv_wa;
  logic [FB-1:0]    prv_wd;
  logic [FB-1:0]    mv_ra;

  logic [31:0]      f_ext;
  logic [31:0]      vproc_ext;
  logic [31:0]      vpage_ext;

  assign pid_ext  = 32'(in_pid);
  assign page_ext = 32'(in_page);
  assign pid_in   = pid_ext[PID_W-1:0];
  assign page_in  = page_ext[PAGE_NUMBER_BITS-1:0];
  assign used_ext = 32'(used_r);
  assign f_free   = used_ext[FB-1:0];

  assign hit_c  = (32'(f_r) < used_ext) && (own_rd_r == {pid_r, page_r});
  assign full_c = (used_ext == FRAMES);

  assign st.pid_ok    = (pid_ext < PROCESSES);
  assign st.need_move = hit_c ? (policy_r && (f_r != newest_r)) : full_c;
  assign st.more_move = (f_r != newest_r);
  assign st.out_free  = !out_vld_r || out_tready;

  always_comb begin
    pt_we  = 1'b0;
    pt_wd  = f_r;
    own_we = 1'b0;
    own_wa = f_r;
    nxt_we = 1'b0;
    nxt_wa = newest_r;
    nxt_wd = f_r;
    prv_we = 1'b0;
    prv_wa = f_r;
    prv_wd = newest_r;
    own_re = 1'b0;
    own_ra = oldest_r;
    mv_ra  = hit_c ? f_r : oldest_r;
    case (cmd.op)
      pffl_pkg::OP_OWNRD: begin
        own_re = 1'b1;
        own_ra = pt_rd_r;
      end
      pffl_pkg::OP_CHECK: begin
        own_re = 1'b1;
        if (!hit_c && !full_c) begin
          pt_we  = 1'b1;
          pt_wd  = f_free;
          own_we = 1'b1;
          own_wa = f_free;
          if (used_r != '0) begin
            prv_we = 1'b1;
            prv_wa = f_free;
            nxt_we = 1'b1;
            nxt_wd = f_free;
          end
        end
      end
      pffl_pkg::OP_MOVE1: begin
        if (ev_r) begin
          pt_we  = 1'b1;
          own_we = 1'b1;
        end
        // Unlink a frame from the middle of the list.
        if ((f_r != newest_r) && (f_r != oldest_r)) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_r;
          nxt_wd = nxt_rd_r;
          prv_we = 1'b1;
          prv_wa = nxt_rd_r;
          prv_wd = prv_rd_r;
        end
      end
      pffl_pkg::OP_MOVE2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[{pid_r, page_r}] <= pt_wd;
    if (cmd.op == pffl_pkg::OP_ACCEPT) pt_rd_r <= pt_mem[{pid_in, page_in}];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_wa] <= {pid_r, page_r};
    if (own_re) own_rd_r <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (cmd.op == pffl_pkg::OP_CHECK) begin
      nxt_rd_r <= nxt_mem[mv_ra];
      prv_rd_r <= prv_mem[mv_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      oldest_r  <= '0;
      newest_r  <= '0;
      policy_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        hit_cnt_r[i]   <= '0;
        fault_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) policy_r <= cfg_wr_data;
      if (cmd.op == pffl_pkg::OP_FINISH) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (cmd.op)
        pffl_pkg::OP_CHECK: begin
          if (hit_c) begin
            hit_cnt_r[pid_r] <= pffl_pkg::sat_inc(hit_cnt_r[pid_r]);
          end else begin
            fault_cnt_r[pid_r] <= pffl_pkg::sat_inc(fault_cnt_r[pid_r]);
            if (!full_c) begin
              if (used_r == '0) oldest_r <= f_free;
              newest_r <= f_free;
              used_r   <= used_r + 1'b1;
            end
          end
        end
        pffl_pkg::OP_MOVE1: begin
          if ((f_r != newest_r) && (f_r == oldest_r)) oldest_r <= nxt_rd_r;
        end
        pffl_pkg::OP_MOVE2: begin
          newest_r <= f_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign f_ext     = 32'(f_r);
  assign vproc_ext = 32'(vproc_r);
  assign vpage_ext = 32'(vpage_r);

  // Per-access payload.
  always_ff @(posedge clk) begin
    case (cmd.op)
      pffl_pkg::OP_ACCEPT: begin
        pid_r   <= pid_in;
        page_r  <= page_in;
        hit_r   <= 1'b0;
        ev_r    <= 1'b0;
        vproc_r <= '0;
        vpage_r <= '0;
      end
      pffl_pkg::OP_OWNRD: begin
        f_r <= pt_rd_r;
      end
      pffl_pkg::OP_CHECK: begin
        hit_r <= hit_c;
        if (!hit_c) begin
          if (full_c) begin
            f_r  <= oldest_r;
            ev_r <= 1'b1;
          end else begin
            f_r <= f_free;
          end
        end
      end
      pffl_pkg::OP_MOVE1: begin
        if (ev_r) begin
          vproc_r <= own_rd_r[OWN_W-1:PAGE_NUMBER_BITS];
          vpage_r <= own_rd_r[PAGE_NUMBER_BITS-1:0];
        end
      end
      pffl_pkg::OP_FINISH: begin
        out_data_r <= {4'b0000, fault_cnt_r[pid_r], hit_cnt_r[pid_r],
                       vpage_ext[pffl_pkg::PAGE_FIELD_W-1:0],
                       vproc_ext[pffl_pkg::PID_FIELD_W-1:0], ev_r,
                       f_ext[pffl_pkg::FRAME_FIELD_W-1:0], hit_r};
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/page_frame_fifo_lru_replacer_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_fifo_lru_replacer_top: page frame allocator, FIFO or LRU
// Translates process/page accesses to physical frames, evicting the oldest
// frame when the pool is full, and reports per-process hit/fault totals.
// ----------------------------------------------------------------------------
// One access is handled at a time. A FIFO-mode hit, or a fault while free
// frames remain, passes through table read, owner read and check before its
// result is registered; an LRU hit that relinks its frame, or an eviction,
// adds the relink steps (only the first of them when only one frame exists).
// The steps follow the chain of registered memory reads: page table, then
// frame owner, then the recency links, each followed by its write-back.
// Residency is decided by matching the frame's owner against the access, so
// the page table is usable right after reset with no clearing pass. A
// finished result waits in the output register while the next access is
// already taken in.
module page_frame_fifo_lru_replacer_top #(
  parameter int PROCESSES        = pffl_pkg::PROCESSES_DEF,
  parameter int PAGE_NUMBER_BITS = pffl_pkg::PAGE_BITS_DEF,
  parameter int FRAMES           = pffl_pkg::FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // process_id [1:0], page_number [13:2]
  input  logic [pffl_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit [0], frame [4:1], evicted [5], victim_process [7:6],
  // victim_page [19:8], hit_total [51:20], fault_total [83:52]
  output logic [pffl_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);

  pffl_pkg::cmd_t    cmd;
  pffl_pkg::status_t st;

  pffl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pffl_dp #(
    .PROCESSES        (PROCESSES),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS),
    .FRAMES           (FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_pid      (in_tdata[1:0]),
    .in_page     (in_tdata[13:2]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // An accepted in-range access keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && st.pid_ok) |=> !in_tready)
    else $error("input reopened while an access was in progress");

  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pffl_pkg::OP_MOVE2) |-> ($past(cmd.op) == pffl_pkg::OP_MOVE1))
    else $error("relink second step without the first");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pffl_pkg::OP_FINISH) |=> out_tvalid)
    else $error("finished access did not present a result");

endmodule

// ===== bench/page_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_checker: result predictor and scoreboard for the page replacer
// Watches the access and result channels and the policy register, keeps its
// own page table, frame owners and recency order, and compares every result
// transfer field by field with the oldest predicted translation.
// ----------------------------------------------------------------------------
module page_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int NPROC = pffl_pkg::PROCESSES_DEF;
  localparam int NFRM  = pffl_pkg::FRAMES_DEF;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame;
    logic        evicted;
    logic [1:0]  victim_process;
    logic [11:0] victim_page;
    logic [31:0] hit_total;
    logic [31:0] fault_total;
  } translation_t;

  logic        lru_mode;
  logic        resident [NPROC*4096];
  logic [3:0]  mapped_frame [NPROC*4096];
  logic [1:0]  owner_proc [NFRM];
  logic [11:0] owner_page [NFRM];
  logic [3:0]  link_next [NFRM];
  logic [3:0]  link_prev [NFRM];
  logic [3:0]  oldest, newest;
  int          used;
  logic [31:0] hits [NPROC];
  logic [31:0] faults [NPROC];
  translation_t expected_q[$];

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic touch_newest(input logic [3:0] f);
    if (f == newest) return;
    if (f == oldest) oldest = link_next[f];
    else begin
      link_next[link_prev[f]] = link_next[f];
      link_prev[link_next[f]] = link_prev[f];
    end
    link_prev[f] = newest;
    link_next[newest] = f;
    newest = f;
  endtask

  task automatic translate(input logic [1:0] pid, input logic [11:0] page);
    translation_t t;
    int idx, vidx;
    logic [3:0] f;
    t = '0;
    idx = pid * 4096 + page;
    if (resident[idx]) begin
      t.hit = 1'b1;
      f = mapped_frame[idx];
      hits[pid] = bump(hits[pid]);
      if (lru_mode) touch_newest(f);
    end else begin
      faults[pid] = bump(faults[pid]);
      if (used < NFRM) begin
        f = used[3:0];
        if (used == 0) oldest = f;
        else begin
          link_prev[f] = newest;
          link_next[newest] = f;
        end
        newest = f;
        used++;
      end else begin
        f = oldest;
        t.evicted = 1'b1;
        t.victim_process = owner_proc[f];
        t.victim_page = owner_page[f];
        vidx = owner_proc[f] * 4096 + owner_page[f];
        resident[vidx] = 1'b0;
        touch_newest(f);
      end
      owner_proc[f] = pid;
      owner_page[f] = page;
      resident[idx] = 1'b1;
      mapped_frame[idx] = f;
    end
    t.frame = f;
    t.hit_total = hits[pid];
    t.fault_total = faults[pid];
    expected_q.push_back(t);
  endtask

  task automatic compare(input logic [87:0] d);
    translation_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no access outstanding: %h", d);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (d[0] !== e.hit) begin
      $error("hit: expected %0d, got %0d", e.hit, d[0]); fail_count++;
    end
    if (d[4:1] !== e.frame) begin
      $error("frame: expected %0d, got %0d", e.frame, d[4:1]); fail_count++;
    end
    if (d[5] !== e.evicted) begin
      $error("evicted: expected %0d, got %0d", e.evicted, d[5]); fail_count++;
    end
    if (d[7:6] !== e.victim_process) begin
      $error("victim_process: expected %0d, got %0d", e.victim_process, d[7:6]);
      fail_count++;
    end
    if (d[19:8] !== e.victim_page) begin
      $error("victim_page: expected %0d, got %0d", e.victim_page, d[19:8]);
      fail_count++;
    end
    if (d[51:20] !== e.hit_total) begin
      $error("hit_total: expected %0d, got %0d", e.hit_total, d[51:20]);
      fail_count++;
    end
    if (d[83:52] !== e.fault_total) begin
      $error("fault_total: expected %0d, got %0d", e.fault_total, d[83:52]);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lru_mode = 1'b0;
      foreach (resident[i]) resident[i] = 1'b0;
      oldest = '0;
      newest = '0;
      used = 0;
      foreach (hits[i]) begin
        hits[i] = '0;
        faults[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        compare(out_tdata);
        result_count++;
      end
      if (in_tvalid && in_tready && in_tdata[1:0] < NPROC)
        translate(in_tdata[1:0], in_tdata[13:2]);
      if (cfg_wr_en) lru_mode = cfg_wr_data;
    end
    pending_count = expected_q.size();
  end
endmodule

// ===== bench/page_frame_fifo_lru_replacer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_fifo_lru_replacer_top_tb: stimulus and verdict for the replacer
// Drives directed and random page accesses in FIFO and LRU phases under
// several idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module page_frame_fifo_lru_replacer_top_tb;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  int          fail_count, pending_count, result_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic [11:0] hot_pages [8];

  page_frame_fifo_lru_replacer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  page_frame_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random; the rate changes with the phase.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The valid stays up after a transfer; the next access or an idle cycle
  // replaces it, and drain() drops it before the sender goes quiet.
  task automatic send_access(input logic [1:0] pid, input logic [11:0] page);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, page, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_policy(input logic p);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly a working set of up to 96 process/page pairs against 16 frames, so
  // hits, LRU relinks and evictions occur; the rest is spread over all pages.
  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_access(2'($urandom_range(3)),
                    hot_pages[$urandom_range(7)] ^ 12'($urandom_range(2)));
      else
        send_access(2'($urandom_range(3)), 12'($urandom));
    end
  endtask

  initial begin
    cycle_count    = 0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (hot_pages[i]) hot_pages[i] = 12'($urandom);
    hot_pages[0] = 12'h000;
    hot_pages[1] = 12'hFFF;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, hits, fill of the pool, evictions in FIFO.
    send_access(2'd0, 12'h000);
    send_access(2'd3, 12'hFFF);
    send_access(2'd0, 12'h000);
    send_access(2'd3, 12'hFFF);
    for (int i = 0; i < 16; i++) send_access(2'(i), 12'(i * 257));
    send_access(2'd0, 12'h000);
    send_access(2'd2, 12'hAAA);
    send_access(2'd1, 12'h555);

    // LRU: faults evict, then hits follow, the last relinking a mid-list frame.
    set_policy(POLICY_LRU);
    send_access(2'd3, 12'hFFF);
    send_access(2'd1, 12'h101);
    send_access(2'd1, 12'h101);
    send_access(2'd0, 12'h123);
    send_access(2'd3, 12'hFFF);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      set_policy(ph[0] ? POLICY_LRU : POLICY_FIFO);
      random_phase(110);
      // Hold off until the pipeline is empty, then continue mid-phase.
      if (ph == 3) drain();
      // Five more accesses end the phase; the next policy write drains first.
      random_phase(5);
    end

    drain();
    $display("Covered %0d results over FIFO and LRU phases with fills, hits,",
             result_count);
    $display("relinks and evictions under sender idling and receiver stalls.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/pffl_pkg.sv
rtl/core/pffl_ctrl.sv
rtl/core/pffl_dp.sv
rtl/core/page_frame_fifo_lru_replacer_top.sv
bench/page_frame_checker.sv
bench/page_frame_fifo_lru_replacer_top_tb.sv
